// ----- src/stok_pkg.sv -----
// Package: types, codes and keyword tables shared by the source tokenizer files.
`default_nettype none
package stok_pkg;

  localparam int KEYWORD_COUNT_DEF  = 8;
  localparam int POSITION_WIDTH_DEF = 24;
  localparam int KW_TABLE   = 8;
  localparam int KW_MAX_LEN = 8;
  localparam int LINE_W     = 24;
  localparam int COL_W      = 16;
  localparam int POS_OUT_W  = 24;
  localparam int RUN_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDENT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LIMIT = 2'd2;

  localparam logic [6:0]  IDENT_LIMIT_RST  = 7'd70;
  localparam logic [5:0]  NUMBER_LIMIT_RST = 6'd20;
  localparam logic [11:0] STRING_LIMIT_RST = 12'd1023;

  localparam logic [4:0] KIND_IDENT   = 5'd26;
  localparam logic [4:0] KIND_KEYWORD = 5'd27;
  localparam logic [4:0] KIND_NUMBER  = 5'd28;
  localparam logic [4:0] KIND_STRING  = 5'd29;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_IDENT_LONG = 3'd1;
  localparam logic [2:0] ERR_NUM_LONG   = 3'd2;
  localparam logic [2:0] ERR_TWO_DOTS   = 3'd3;
  localparam logic [2:0] ERR_STR_LONG   = 3'd4;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd5;

  typedef enum logic [2:0] {
    PC_NONE, PC_OP, PC_IDENT, PC_NUM, PC_STR
  } pend_class_t;

  typedef struct packed {
    logic [4:0]           token_kind;
    logic [2:0]           keyword_id;
    logic [LINE_W-1:0]    line_number;
    logic [COL_W-1:0]     column_number;
    logic [POS_OUT_W-1:0] byte_position;
    logic [RUN_W-1:0]     token_length;
    logic [2:0]           error_code;
    logic                 last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

  localparam logic [7:0] KW_TEXT [KW_TABLE][KW_MAX_LEN] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", "i", "f", 8'h00, 8'h00},
    '{"l", "o", "c", "a", "l", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_TABLE] = '{3'd2, 3'd4, 3'd6, 3'd5, 3'd5, 3'd4, 3'd5, 3'd2};

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic takes_eq(input logic [7:0] c);
    return c inside {"+", "-", "/", "%", ">", "<", "=", "!"};
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return c inside {"*", ",", ";", ":", "(", ")", "{", "}", "[", "]"};
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c, input logic eq);
    logic [4:0] k;
    case (c)
      "+":     k = eq ? 5'd1 : 5'd0;
      "-":     k = eq ? 5'd3 : 5'd2;
      "*":     k = 5'd4;
      "/":     k = eq ? 5'd6 : 5'd5;
      "%":     k = eq ? 5'd8 : 5'd7;
      ">":     k = eq ? 5'd10 : 5'd9;
      "<":     k = eq ? 5'd12 : 5'd11;
      "=":     k = eq ? 5'd14 : 5'd13;
      "!":     k = eq ? 5'd16 : 5'd15;
      ",":     k = 5'd17;
      ";":     k = 5'd18;
      ":":     k = 5'd19;
      "(":     k = 5'd20;
      ")":     k = 5'd21;
      "{":     k = 5'd22;
      "}":     k = 5'd23;
      "[":     k = 5'd24;
      "]":     k = 5'd25;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic [2:0] kw,
                                  input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
                                  input logic [POS_OUT_W-1:0] pos, input logic [RUN_W-1:0] len,
                                  input logic [2:0] err);
    res_t r;
    r.vld                = 1'b1;
    r.item.token_kind    = kind;
    r.item.keyword_id    = kw;
    r.item.line_number   = ln;
    r.item.column_number = col;
    r.item.byte_position = pos;
    r.item.token_length  = len;
    r.item.error_code    = err;
    r.item.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/stok_if.sv -----
// Interfaces: the source byte channel and the token result channel.
`default_nettype none
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source(output valid, source_byte, end_of_source, input ready);
  modport sink(input valid, source_byte, end_of_source, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [2:0]  keyword_id;
  logic [23:0] line_number;
  logic [15:0] column_number;
  logic [23:0] byte_position;
  logic [11:0] token_length;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source(output valid, token_kind, keyword_id, line_number, column_number,
                 byte_position, token_length, error_code, last_of_run, input ready);
  modport sink(input valid, token_kind, keyword_id, line_number, column_number,
               byte_position, token_length, error_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/stok_result_fifo.sv -----
// Four-entry result queue that takes up to two results per cycle and gives one.
`default_nettype none
module stok_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  stok_pkg::res_t    push0,
  input  stok_pkg::res_t    push1,
  input  logic              pop,
  output logic              head_vld,
  output stok_pkg::out_item_t head,
  output logic              room2
);
  import stok_pkg::*;

  out_item_t  mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       do_pop;

  assign head_vld = (count_r != 3'd0);
  assign head     = mem[rd_ptr_r];
  assign room2    = (count_r <= 3'd2);
  assign do_pop   = pop && head_vld;
  assign n_push   = {1'b0, push0.vld} + {1'b0, push1.vld};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, n_push} - {2'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0.vld) begin
      mem[wr_ptr_r] <= push0.item;
    end
    if (push1.vld) begin
      mem[wr_ptr_r + 2'd1] <= push1.item;
    end
  end

endmodule
`default_nettype wire

// ----- src/source_tokenizer.sv -----
// Top level of the source tokenizer: byte stream in, token results out.
//
//   channel    | direction | handshake    | payload
//   in_stream  | in        | valid/ready  | source_byte, end_of_source
//   out_stream | out       | valid/ready  | token fields, error_code, last_of_run
//   cfg_*      | in        | write enable | cfg_index, cfg_wdata
//
// A byte is taken in every cycle while the four-entry result queue has room for two results.
// An item is tokenized in the cycle it is accepted; its results are written into the result queue.
// The rate is one item per cycle while items give one result or none and out_stream is not
// stalled; a byte that gives two results queues both, and they leave one at a time.
// Synchronous reset empties the queue and returns the tokenizer state and the limit
// registers to their reset values.
`default_nettype none
module source_tokenizer #(
  parameter int KEYWORD_COUNT  = stok_pkg::KEYWORD_COUNT_DEF,
  parameter int POSITION_WIDTH = stok_pkg::POSITION_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stok_in_if.sink                         in_stream,
  stok_out_if.source                      out_stream,
  input  logic                            cfg_we,
  input  logic [stok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stok_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stok_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [6:0]  ident_limit_r;
  logic [5:0]  number_limit_r;
  logic [11:0] string_limit_r;

  pend_class_t             cls_r, cls_nxt;
  logic [7:0]              op_r, op_nxt;
  logic [RUN_W-1:0]        run_r, run_nxt;
  logic                    dot_r, dot_nxt;
  logic [KW_TABLE-1:0]     hits_r, hits_nxt;
  logic [LINE_W-1:0]       line_r, line_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [LINE_W-1:0]       sline_r, sline_nxt;
  logic [COL_W-1:0]        scol_r, scol_nxt;
  logic [POSITION_WIDTH-1:0] spos_r, spos_nxt;
  logic                    halt_r, halt_nxt;

  logic      in_fire;
  logic      room2;
  logic      head_vld;
  out_item_t head;
  res_t      slot0, slot1;
  logic [KW_TABLE-1:0] kw_mask;

  always_comb begin
    for (int k = 0; k < KW_TABLE; k++) begin
      kw_mask[k] = (k < KEYWORD_COUNT);
    end
  end

  function automatic res_t flush_res(input pend_class_t cls, input logic [7:0] op,
                                     input logic [KW_TABLE-1:0] hits,
                                     input logic [RUN_W-1:0] run,
                                     input logic [LINE_W-1:0] sl, input logic [COL_W-1:0] sc,
                                     input logic [POSITION_WIDTH-1:0] sp);
    res_t       r;
    logic [4:0] kind;
    logic [2:0] id;
    r    = '0;
    kind = KIND_IDENT;
    id   = 3'd0;
    case (cls)
      PC_OP: begin
        r = mk_res(op_kind(op, 1'b0), 3'd0, sl, sc, POS_OUT_W'(sp), 12'd1, ERR_NONE);
      end
      PC_IDENT: begin
        for (int k = KW_TABLE - 1; k >= 0; k--) begin
          if (hits[k] && ({9'd0, KW_LEN[k]} == run)) begin
            kind = KIND_KEYWORD;
            id   = 3'(k);
          end
        end
        r = mk_res(kind, id, sl, sc, POS_OUT_W'(sp), run, ERR_NONE);
      end
      PC_NUM: begin
        r = mk_res(KIND_NUMBER, 3'd0, sl, sc, POS_OUT_W'(sp), run, ERR_NONE);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign in_fire         = in_stream.valid && in_stream.ready;
  assign in_stream.ready = room2;

  always_comb begin
    logic [7:0]         b;
    logic               eos;
    logic [COL_W-1:0]   col_v;
    logic [POSITION_WIDTH-1:0] pos_v;
    logic [POS_OUT_W-1:0] pos_o;
    logic               handled;
    res_t               ra, rb, rc;
    logic [KW_TABLE-1:0] nh;

    b        = in_stream.source_byte;
    eos      = in_stream.end_of_source;
    cls_nxt  = cls_r;
    op_nxt   = op_r;
    run_nxt  = run_r;
    dot_nxt  = dot_r;
    hits_nxt = hits_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;
    sline_nxt = sline_r;
    scol_nxt = scol_r;
    spos_nxt = spos_r;
    halt_nxt = halt_r;
    ra = '0;
    rb = '0;
    rc = '0;
    handled = 1'b0;
    col_v = col_r;
    pos_v = pos_r;
    pos_o = '0;
    nh = '0;

    if (!halt_r) begin
      if (b == 8'h0A) begin
        if (line_r != '1) begin
          line_nxt = line_r + 1'b1;
        end
        col_v = '0;
      end
      col_nxt = (col_v != '1) ? col_v + 1'b1 : col_v;
      pos_v   = pos_r;
      pos_o   = POS_OUT_W'(pos_r);
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end

      case (cls_r)
        PC_OP: begin
          if (b == "=") begin
            ra = mk_res(op_kind(op_r, 1'b1), 3'd0, line_nxt, col_v, pos_o, 12'd2, ERR_NONE);
            cls_nxt = PC_NONE;
            handled = 1'b1;
          end else begin
            ra = flush_res(cls_r, op_r, hits_r, run_r, sline_r, scol_r, spos_r);
            cls_nxt = PC_NONE;
          end
        end
        PC_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            if (run_r >= {5'd0, ident_limit_r}) begin
              ra = mk_res(KIND_IDENT, 3'd0, line_nxt, col_v, pos_o, run_r, ERR_IDENT_LONG);
              halt_nxt = 1'b1;
            end else begin
              for (int k = 0; k < KW_TABLE; k++) begin
                nh[k] = hits_r[k] && (run_r < {9'd0, KW_LEN[k]})
                        && (KW_TEXT[k][run_r[2:0]] == b);
              end
              hits_nxt  = nh;
              run_nxt   = run_r + 1'b1;
              sline_nxt = line_nxt;
              scol_nxt  = col_v;
              spos_nxt  = pos_v;
            end
            handled = 1'b1;
          end else begin
            ra = flush_res(cls_r, op_r, hits_r, run_r, sline_r, scol_r, spos_r);
            cls_nxt = PC_NONE;
          end
        end
        PC_NUM: begin
          if (is_digit(b) || (b == ".")) begin
            if ((b == ".") && dot_r) begin
              ra = mk_res(KIND_NUMBER, 3'd0, line_nxt, col_v, pos_o, run_r, ERR_TWO_DOTS);
              halt_nxt = 1'b1;
            end else if (run_r >= {6'd0, number_limit_r}) begin
              ra = mk_res(KIND_NUMBER, 3'd0, line_nxt, col_v, pos_o, run_r, ERR_NUM_LONG);
              halt_nxt = 1'b1;
            end else begin
              if (b == ".") begin
                dot_nxt = 1'b1;
              end
              run_nxt   = run_r + 1'b1;
              sline_nxt = line_nxt;
              scol_nxt  = col_v;
              spos_nxt  = pos_v;
            end
            handled = 1'b1;
          end else begin
            ra = flush_res(cls_r, op_r, hits_r, run_r, sline_r, scol_r, spos_r);
            cls_nxt = PC_NONE;
          end
        end
        PC_STR: begin
          if (b == "\"") begin
            ra = mk_res(KIND_STRING, 3'd0, line_nxt, col_v, pos_o, run_r, ERR_NONE);
            cls_nxt = PC_NONE;
          end else if (run_r >= string_limit_r) begin
            ra = mk_res(KIND_STRING, 3'd0, line_nxt, col_v, pos_o, run_r, ERR_STR_LONG);
            halt_nxt = 1'b1;
          end else if (run_r != '1) begin
            run_nxt = run_r + 1'b1;
          end
          handled = 1'b1;
        end
        default: cls_nxt = PC_NONE;
      endcase

      if (!handled && !halt_nxt) begin
        if (is_letter(b)) begin
          cls_nxt = PC_IDENT;
          run_nxt = 12'd1;
          for (int k = 0; k < KW_TABLE; k++) begin
            nh[k] = kw_mask[k] && (KW_TEXT[k][0] == b);
          end
          hits_nxt  = nh;
          sline_nxt = line_nxt;
          scol_nxt  = col_v;
          spos_nxt  = pos_v;
        end else if (is_digit(b)) begin
          cls_nxt   = PC_NUM;
          run_nxt   = 12'd1;
          dot_nxt   = 1'b0;
          sline_nxt = line_nxt;
          scol_nxt  = col_v;
          spos_nxt  = pos_v;
        end else if (b == "\"") begin
          cls_nxt = PC_STR;
          run_nxt = '0;
        end else if (takes_eq(b)) begin
          cls_nxt   = PC_OP;
          op_nxt    = b;
          sline_nxt = line_nxt;
          scol_nxt  = col_v;
          spos_nxt  = pos_v;
        end else if (is_single(b)) begin
          rb = mk_res(op_kind(b, 1'b0), 3'd0, line_nxt, col_v, pos_o, 12'd1, ERR_NONE);
        end
      end

      if (eos && !halt_nxt) begin
        if (cls_nxt == PC_STR) begin
          rc = mk_res(KIND_STRING, 3'd0, line_nxt, col_v, pos_o, run_nxt, ERR_UNCLOSED);
        end else begin
          rc = flush_res(cls_nxt, op_nxt, hits_nxt, run_nxt, sline_nxt, scol_nxt, spos_nxt);
        end
      end
    end

    if (eos) begin
      cls_nxt   = PC_NONE;
      op_nxt    = '0;
      run_nxt   = '0;
      dot_nxt   = 1'b0;
      hits_nxt  = '0;
      line_nxt  = LINE_W'(1);
      col_nxt   = COL_W'(1);
      pos_nxt   = '0;
      sline_nxt = LINE_W'(1);
      scol_nxt  = '0;
      spos_nxt  = '0;
      halt_nxt  = 1'b0;
    end

    slot0 = '0;
    slot1 = '0;
    if (ra.vld) begin
      slot0 = ra;
    end
    if (rb.vld) begin
      if (slot0.vld) slot1 = rb;
      else slot0 = rb;
    end
    if (rc.vld) begin
      if (slot0.vld) slot1 = rc;
      else slot0 = rc;
    end
    if (slot1.vld) begin
      slot1.item.last_of_run = 1'b1;
    end else if (slot0.vld) begin
      slot0.item.last_of_run = 1'b1;
    end
    if (!in_fire) begin
      slot0 = '0;
      slot1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r   <= PC_NONE;
      op_r    <= '0;
      run_r   <= '0;
      dot_r   <= 1'b0;
      hits_r  <= '0;
      line_r  <= LINE_W'(1);
      col_r   <= COL_W'(1);
      pos_r   <= '0;
      sline_r <= LINE_W'(1);
      scol_r  <= '0;
      spos_r  <= '0;
      halt_r  <= 1'b0;
    end else if (in_fire) begin
      cls_r   <= cls_nxt;
      op_r    <= op_nxt;
      run_r   <= run_nxt;
      dot_r   <= dot_nxt;
      hits_r  <= hits_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      spos_r  <= spos_nxt;
      halt_r  <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_limit_r  <= IDENT_LIMIT_RST;
      number_limit_r <= NUMBER_LIMIT_RST;
      string_limit_r <= STRING_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDENT_LIMIT:  ident_limit_r  <= cfg_wdata[6:0];
        CFG_NUMBER_LIMIT: number_limit_r <= cfg_wdata[5:0];
        CFG_STRING_LIMIT: string_limit_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  stok_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (slot0),
    .push1    (slot1),
    .pop      (out_stream.ready),
    .head_vld (head_vld),
    .head     (head),
    .room2    (room2)
  );

  assign out_stream.valid         = head_vld;
  assign out_stream.token_kind    = head.token_kind;
  assign out_stream.keyword_id    = head.keyword_id;
  assign out_stream.line_number   = head.line_number;
  assign out_stream.column_number = head.column_number;
  assign out_stream.byte_position = head.byte_position;
  assign out_stream.token_length  = head.token_length;
  assign out_stream.error_code    = head.error_code;
  assign out_stream.last_of_run   = head.last_of_run;

endmodule
`default_nettype wire

// ----- src/stok_checker.sv -----
// Port checker for the source tokenizer and its bind statement.
`default_nettype none
module stok_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_kind,
  input logic [2:0]  keyword_id,
  input logic [11:0] token_length
);
  import stok_pkg::*;

  // A result that is stalled stays valid and keeps its token kind and token length.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_length))
    else $error("stalled result changed");

  // Reset empties the result queue.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Only keywords carry a nonzero keyword index.
  a_kw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (keyword_id != 3'd0) |-> token_kind == KIND_KEYWORD)
    else $error("keyword index on a non-keyword item");

  // Operators are one or two characters long.
  a_oplen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_kind < KIND_IDENT) |-> (token_length == 12'd1 || token_length == 12'd2))
    else $error("operator item with bad length");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .token_kind   (out_stream.token_kind),
  .keyword_id   (out_stream.keyword_id),
  .token_length (out_stream.token_length)
);
`default_nettype wire
